// ===== hw/rtl/segment_box_swept_hit_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the swept point versus box block
// Shared helpers for the concurrent checks bound to the top level.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_SWEPT_HIT_TOP_MACROS_SVH
`define SEGMENT_BOX_SWEPT_HIT_TOP_MACROS_SVH

// Check that is suspended while reset is high.
`define SBSH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that holds in every cycle, reset included.
`define SBSH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sbsh_pkg.sv =====
// ----------------------------------------------------------------------------
// Swept hit package
// Types and constants shared by the swept point versus box pipeline.
// ----------------------------------------------------------------------------
package sbsh_pkg;

   localparam int TIME_BITS = 16;
   localparam int TW        = TIME_BITS + 1;
   localparam int QBITS     = TIME_BITS + 1;
   localparam int SETUP_LAT = 2;
   localparam int LANE_LAT  = QBITS + 2;
   localparam int LATENCY   = SETUP_LAT + LANE_LAT + 1;
   localparam int SIDES     = 4;

   localparam logic [TW-1:0] T_ONE     = TW'(65536);
   localparam logic [TW-1:0] EPS_RESET = TW'(655);

   typedef enum logic [1:0] {
      SIDE_LEFT   = 2'd0,
      SIDE_TOP    = 2'd1,
      SIDE_RIGHT  = 2'd2,
      SIDE_BOTTOM = 2'd3
   } side_id_type;

   typedef struct packed {
      logic signed [32:0] n;
      logic signed [31:0] d;
      logic signed [32:0] a;
      logic signed [32:0] b;
      logic signed [32:0] l;
   } diff_type;

   typedef struct packed {
      logic        [31:0] n;
      logic        [31:0] d;
      logic signed [32:0] a;
      logic signed [32:0] b;
      logic signed [32:0] l;
      logic               ok;
   } side_type;

   typedef struct packed {
      logic          hit;
      logic [TW-1:0] t;
   } lane_res_type;

   function automatic logic signed [1:0] normal_x(side_id_type s);
      case (s)
         SIDE_LEFT:  normal_x = -2'sd1;
         SIDE_RIGHT: normal_x = 2'sd1;
         default:    normal_x = 2'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] normal_y(side_id_type s);
      case (s)
         SIDE_TOP:    normal_y = 2'sd1;
         SIDE_BOTTOM: normal_y = -2'sd1;
         default:     normal_y = 2'sd0;
      endcase
   endfunction

endpackage

// ===== hw/rtl/sbsh_setup.sv =====
// ----------------------------------------------------------------------------
// Swept hit setup stages
// Forms the per-side differences, then the sign-normalized divider operands
// and the range and extent flags.
// ----------------------------------------------------------------------------
module sbsh_setup (
   input  logic                                   clock,
   input  logic signed [31:0]                     start_x,
   input  logic signed [31:0]                     start_y,
   input  logic signed [31:0]                     move_x,
   input  logic signed [31:0]                     move_y,
   input  logic signed [31:0]                     box_min_x,
   input  logic signed [31:0]                     box_min_y,
   input  logic signed [31:0]                     box_max_x,
   input  logic signed [31:0]                     box_max_y,
   output sbsh_pkg::side_type [sbsh_pkg::SIDES-1:0] side_out
);

   logic signed [32:0] sx, sy, mx, my, x0, y0, x1, y1;
   sbsh_pkg::diff_type [sbsh_pkg::SIDES-1:0] diff_in, diff_ff;
   sbsh_pkg::side_type [sbsh_pkg::SIDES-1:0] side_in, side_ff;

   assign sx = {start_x[31], start_x};
   assign sy = {start_y[31], start_y};
   assign mx = {move_x[31], move_x};
   assign my = {move_y[31], move_y};
   assign x0 = {box_min_x[31], box_min_x};
   assign y0 = {box_min_y[31], box_min_y};
   assign x1 = {box_max_x[31], box_max_x};
   assign y1 = {box_max_y[31], box_max_y};

   always_comb begin
      diff_in[0].n = x0 - sx;
      diff_in[0].d = move_x;
      diff_in[0].a = sy - y0;
      diff_in[0].b = my;
      diff_in[0].l = y1 - y0;
      diff_in[1].n = y1 - sy;
      diff_in[1].d = move_y;
      diff_in[1].a = sx - x0;
      diff_in[1].b = mx;
      diff_in[1].l = x1 - x0;
      diff_in[2].n = x1 - sx;
      diff_in[2].d = move_x;
      diff_in[2].a = y1 - sy;
      diff_in[2].b = -my;
      diff_in[2].l = y1 - y0;
      diff_in[3].n = y0 - sy;
      diff_in[3].d = move_y;
      diff_in[3].a = x1 - sx;
      diff_in[3].b = -mx;
      diff_in[3].l = x1 - x0;
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   always_comb begin
      logic signed [32:0] de;
      logic signed [32:0] nneg;
      logic signed [32:0] dneg;
      logic               pos;
      logic               rng;
      for (int i = 0; i < sbsh_pkg::SIDES; i++) begin
         de   = {diff_ff[i].d[31], diff_ff[i].d};
         nneg = -diff_ff[i].n;
         dneg = -de;
         pos  = !diff_ff[i].d[31];
         if (pos) begin
            rng = (diff_ff[i].n >= 33'sd0) && (diff_ff[i].n <= de);
         end else begin
            rng = (diff_ff[i].n <= 33'sd0) && (diff_ff[i].n >= de);
         end
         side_in[i].n  = pos ? diff_ff[i].n[31:0] : nneg[31:0];
         side_in[i].d  = pos ? diff_ff[i].d : dneg[31:0];
         side_in[i].a  = diff_ff[i].a;
         side_in[i].b  = diff_ff[i].b;
         side_in[i].l  = diff_ff[i].l;
         side_in[i].ok = (diff_ff[i].d != 32'sd0) && rng && !diff_ff[i].l[32];
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
   end

   assign side_out = side_ff;

endmodule

// ===== hw/rtl/sbsh_lane.sv =====
// ----------------------------------------------------------------------------
// Swept hit side lane
// Pipelined restoring divider for the crossing time, then the registered
// multiply and extent compare for one side of the box.
// ----------------------------------------------------------------------------
module sbsh_lane (
   input  logic                   clock,
   input  sbsh_pkg::side_type     side_in,
   output sbsh_pkg::lane_res_type res_out
);

   localparam int QB = sbsh_pkg::QBITS;

   logic        [31:0]   r_ff [QB];
   logic        [31:0]   d_ff [QB];
   logic        [QB-1:0] q_ff [QB];
   logic signed [32:0]   a_ff [QB];
   logic signed [32:0]   b_ff [QB];
   logic signed [32:0]   l_ff [QB];
   logic                 ok_ff [QB];

   for (genvar j = 0; j < QB; j++) begin : g_div
      logic        [32:0]   rs;
      logic        [32:0]   diff;
      logic                 ge;
      logic        [31:0]   src_d;
      logic        [QB-1:0] src_q;
      logic signed [32:0]   src_a, src_b, src_l;
      logic                 src_ok;

      if (j == 0) begin : g_first
         assign rs     = {1'b0, side_in.n};
         assign src_d  = side_in.d;
         assign src_q  = '0;
         assign src_a  = side_in.a;
         assign src_b  = side_in.b;
         assign src_l  = side_in.l;
         assign src_ok = side_in.ok;
      end else begin : g_next
         assign rs     = {r_ff[j-1], 1'b0};
         assign src_d  = d_ff[j-1];
         assign src_q  = q_ff[j-1];
         assign src_a  = a_ff[j-1];
         assign src_b  = b_ff[j-1];
         assign src_l  = l_ff[j-1];
         assign src_ok = ok_ff[j-1];
      end

      assign diff = rs - {1'b0, src_d};
      assign ge   = (rs >= {1'b0, src_d});

      always_ff @(posedge clock) begin
         r_ff[j]  <= ge ? diff[31:0] : rs[31:0];
         d_ff[j]  <= src_d;
         q_ff[j]  <= {src_q[QB-2:0], ge};
         a_ff[j]  <= src_a;
         b_ff[j]  <= src_b;
         l_ff[j]  <= src_l;
         ok_ff[j] <= src_ok;
      end
   end

   logic signed [50:0]   prod_in, prod_ff;
   logic signed [32:0]   am_ff, lm_ff;
   logic        [QB-1:0] qm_ff;
   logic                 okm_ff;
   logic signed [51:0]   y, lim;
   sbsh_pkg::lane_res_type res_in, res_ff;

   assign prod_in = $signed({1'b0, q_ff[QB-1]}) * b_ff[QB-1];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      am_ff   <= a_ff[QB-1];
      lm_ff   <= l_ff[QB-1];
      qm_ff   <= q_ff[QB-1];
      okm_ff  <= ok_ff[QB-1];
   end

   assign y   = $signed({{3{am_ff[32]}}, am_ff, 16'b0}) + $signed({prod_ff[50], prod_ff});
   assign lim = $signed({{3{lm_ff[32]}}, lm_ff, 16'b0});

   always_comb begin
      res_in.hit = okm_ff && !y[51] && (y <= lim);
      res_in.t   = qm_ff;
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res_out = res_ff;

endmodule

// ===== hw/rtl/sbsh_pick.sv =====
// ----------------------------------------------------------------------------
// Swept hit selection stage
// Picks the earliest side hit, forms the backed-off time and registers
// the result item.
// ----------------------------------------------------------------------------
module sbsh_pick (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        valid_in,
   input  sbsh_pkg::lane_res_type [sbsh_pkg::SIDES-1:0] res_in,
   input  logic [sbsh_pkg::TW-1:0]                     eps,
   output logic                                        rsp_valid,
   output logic                                        rsp_hit,
   output logic signed [1:0]                           rsp_normal_x,
   output logic signed [1:0]                           rsp_normal_y,
   output logic [sbsh_pkg::TW-1:0]                     rsp_hit_time,
   output logic [sbsh_pkg::TW-1:0]                     rsp_safe_time
);

   logic                    found;
   sbsh_pkg::side_id_type   best;
   logic [sbsh_pkg::TW-1:0] bt;
   logic signed [sbsh_pkg::TW:0] sd;

   logic                    valid_ff;
   logic                    hit_ff;
   logic signed [1:0]       nx_ff, ny_ff;
   logic [sbsh_pkg::TW-1:0] time_ff, safe_ff;

   always_comb begin
      found = 1'b0;
      best  = sbsh_pkg::SIDE_LEFT;
      bt    = sbsh_pkg::T_ONE;
      for (int i = 0; i < sbsh_pkg::SIDES; i++) begin
         if (res_in[i].hit && (!found || res_in[i].t < bt)) begin
            found = 1'b1;
            best  = sbsh_pkg::side_id_type'(2'(i));
            bt    = res_in[i].t;
         end
      end
   end

   assign sd = $signed({1'b0, bt}) - $signed({1'b0, eps});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= found;
      nx_ff   <= found ? sbsh_pkg::normal_x(best) : 2'sd0;
      ny_ff   <= found ? sbsh_pkg::normal_y(best) : 2'sd0;
      time_ff <= found ? bt : sbsh_pkg::T_ONE;
      safe_ff <= (found && !sd[sbsh_pkg::TW]) ? sd[sbsh_pkg::TW-1:0] : '0;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_normal_x  = nx_ff;
   assign rsp_normal_y  = ny_ff;
   assign rsp_hit_time  = time_ff;
   assign rsp_safe_time = safe_ff;

endmodule

// ===== hw/rtl/segment_box_swept_hit_top.sv =====
// ----------------------------------------------------------------------------
// Swept point versus box hit test
// The rsp_valid strobe follows start through the setup registers, the
// 17-stage crossing-time divider in each side lane, and the checks.
// Throughput is one item per cycle; busy is high only during reset.
// Reset clears the valid pipeline and loads backoff epsilon with 655.
// ----------------------------------------------------------------------------
module segment_box_swept_hit_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [31:0]      req_start_x,
   input  logic signed [31:0]      req_start_y,
   input  logic signed [31:0]      req_move_x,
   input  logic signed [31:0]      req_move_y,
   input  logic signed [31:0]      req_box_min_x,
   input  logic signed [31:0]      req_box_min_y,
   input  logic signed [31:0]      req_box_max_x,
   input  logic signed [31:0]      req_box_max_y,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic signed [1:0]       rsp_normal_x,
   output logic signed [1:0]       rsp_normal_y,
   output logic [sbsh_pkg::TW-1:0] rsp_hit_time,
   output logic [sbsh_pkg::TW-1:0] rsp_safe_time,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [sbsh_pkg::TW-1:0] csr_data
);

   localparam int VLAT = sbsh_pkg::SETUP_LAT + sbsh_pkg::LANE_LAT;

   logic [sbsh_pkg::TW-1:0] eps_ff;
   logic [VLAT-1:0]         v_ff;
   sbsh_pkg::side_type     [sbsh_pkg::SIDES-1:0] side;
   sbsh_pkg::lane_res_type [sbsh_pkg::SIDES-1:0] res;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= sbsh_pkg::EPS_RESET;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[VLAT-2:0], start && !busy};
      end
   end

   sbsh_setup u_setup (
      .clock     (clock),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .move_x    (req_move_x),
      .move_y    (req_move_y),
      .box_min_x (req_box_min_x),
      .box_min_y (req_box_min_y),
      .box_max_x (req_box_max_x),
      .box_max_y (req_box_max_y),
      .side_out  (side)
   );

   for (genvar i = 0; i < sbsh_pkg::SIDES; i++) begin : g_lane
      sbsh_lane u_lane (
         .clock   (clock),
         .side_in (side[i]),
         .res_out (res[i])
      );
   end

   sbsh_pick u_pick (
      .clock         (clock),
      .reset         (reset),
      .valid_in      (v_ff[VLAT-1]),
      .res_in        (res),
      .eps           (eps_ff),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_normal_x  (rsp_normal_x),
      .rsp_normal_y  (rsp_normal_y),
      .rsp_hit_time  (rsp_hit_time),
      .rsp_safe_time (rsp_safe_time)
   );

endmodule

// ===== hw/rtl/sbsh_checker.sv =====
// ----------------------------------------------------------------------------
// Swept hit port checker
// Concurrent checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_box_swept_hit_top_macros.svh"

module sbsh_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic                    rsp_hit,
   input logic signed [1:0]       rsp_normal_x,
   input logic signed [1:0]       rsp_normal_y,
   input logic [sbsh_pkg::TW-1:0] rsp_hit_time,
   input logic [sbsh_pkg::TW-1:0] rsp_safe_time
);

   `SBSH_ASSERT(a_latency, clock, reset, start && !busy |-> ##(sbsh_pkg::LATENCY) rsp_valid, "item result missing")
   `SBSH_ASSERT_ALWAYS(a_no_spurious, clock, rsp_valid |-> $past(start && !busy, sbsh_pkg::LATENCY), "result without item")
   `SBSH_ASSERT(a_miss_fields, clock, reset, rsp_valid && !rsp_hit |-> rsp_hit_time == sbsh_pkg::T_ONE && rsp_normal_x == 2'sd0 && rsp_normal_y == 2'sd0 && rsp_safe_time == '0, "bad miss result")
   `SBSH_ASSERT(a_hit_fields, clock, reset, rsp_valid && rsp_hit |-> rsp_safe_time <= rsp_hit_time && ((rsp_normal_x == 2'sd0) != (rsp_normal_y == 2'sd0)), "bad hit result")

endmodule

bind segment_box_swept_hit_top sbsh_checker u_sbsh_checker (.*);
